/* sv/assert_macros.svh */
// Assertion macros used by the top level of the keyframe interpolator.
// Included by bare name; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent and consequent checked in the same cycle.
`define KLI_ASSERT_IMPL(lbl, clk_s, rst_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KLI_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error(msg);

`else

`define KLI_ASSERT_IMPL(lbl, clk_s, rst_s, pre, post, msg)
`define KLI_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg)

`endif

`endif

/* sv/kli_pkg.sv */
// Shared types and constants of the keyframe linear interpolator.
// No dependencies; every other file of the block but assert_macros.svh uses it.
package kli_pkg;

    localparam int VAL_W   = 32;
    localparam int TIME_W  = 16;
    localparam int LANES   = 4;
    localparam int LANE_W  = 2;
    localparam int FRAC_W  = 17;
    localparam int VIEW_W  = 34;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] REG_BEGIN_FRAME     = 2'd0;
    localparam logic [1:0] REG_COMPONENT_COUNT = 2'd1;
    localparam logic [1:0] REG_KEYFRAME_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        ST_INTERP     = 2'd0,
        ST_HELD_FIRST = 2'd1,
        ST_HELD_LAST  = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD_A,
        S_RD_B,
        S_CAP_B,
        S_DIV,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] begin_frame;
        logic [2:0]  component_count;
        logic [6:0]  keyframe_count;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         entry_index;
        logic [15:0]        entry_time;
        logic signed [31:0] comp0;
        logic signed [31:0] comp1;
        logic signed [31:0] comp2;
        logic signed [31:0] comp3;
        logic [31:0]        current_frame;
        logic [31:0]        query_time;
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;
        logic start;
        logic scan;
        logic rd_b;
        logic cap_b;
        logic mul;
        logic add;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic hit;
        logic last;
        logic interp;
        logic div_busy;
        logic comp_last;
        logic out_free;
    } sts_t;

endpackage

/* sv/kli_if.sv */
// Valid/ready channel interfaces for requests and results of the interpolator.
// Depends on kli_pkg for field widths.
interface kli_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [5:0]                          entry_index;
    logic [kli_pkg::TIME_W-1:0]          entry_time;
    logic signed [kli_pkg::VAL_W-1:0]    comp0;
    logic signed [kli_pkg::VAL_W-1:0]    comp1;
    logic signed [kli_pkg::VAL_W-1:0]    comp2;
    logic signed [kli_pkg::VAL_W-1:0]    comp3;
    logic [kli_pkg::VAL_W-1:0]           current_frame;
    logic [kli_pkg::VAL_W-1:0]           query_time;

    modport source (
        output valid, req_type, entry_index, entry_time,
        output comp0, comp1, comp2, comp3, current_frame, query_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_time,
        input  comp0, comp1, comp2, comp3, current_frame, query_time,
        output ready
    );
endinterface

interface kli_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [kli_pkg::VAL_W-1:0] value0;
    logic signed [kli_pkg::VAL_W-1:0] value1;
    logic signed [kli_pkg::VAL_W-1:0] value2;
    logic signed [kli_pkg::VAL_W-1:0] value3;
    logic [1:0]                       status;

    modport source (
        output valid, value0, value1, value2, value3, status,
        input  ready
    );
    modport sink (
        input  valid, value0, value1, value2, value3, status,
        output ready
    );
endinterface

/* sv/kli_regs.sv */
// APB-style configuration registers of the keyframe interpolator.
// Depends on kli_pkg for the register indexes and the cfg_t type.
module kli_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kli_pkg::ADDR_W-1:0]   paddr,
    input  logic [kli_pkg::DATA_W-1:0]   pwdata,
    output logic [kli_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output kli_pkg::cfg_t                cfg
);

    logic [15:0] begin_frame_reg;
    logic [2:0]  component_count_reg;
    logic [6:0]  keyframe_count_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_frame_reg     <= 16'd0;
            component_count_reg <= 3'd1;
            keyframe_count_reg  <= 7'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                kli_pkg::REG_BEGIN_FRAME:     begin_frame_reg     <= pwdata[15:0];
                kli_pkg::REG_COMPONENT_COUNT: component_count_reg <= pwdata[2:0];
                kli_pkg::REG_KEYFRAME_COUNT:  keyframe_count_reg  <= pwdata[6:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            kli_pkg::REG_BEGIN_FRAME:     prdata = {16'd0, begin_frame_reg};
            kli_pkg::REG_COMPONENT_COUNT: prdata = {29'd0, component_count_reg};
            kli_pkg::REG_KEYFRAME_COUNT:  prdata = {25'd0, keyframe_count_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.begin_frame     = begin_frame_reg;
    assign cfg.component_count = component_count_reg;
    assign cfg.keyframe_count  = keyframe_count_reg;

endmodule

/* sv/kli_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, for the blend fraction.
// Depends on kli_pkg for the step count.
module kli_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic        busy,
    output logic [31:0] quot
);

    logic [kli_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [15:0]                   rem_reg;
    logic [31:0]                   q_reg;
    logic [15:0]                   den_reg;
    logic [16:0]                   trial;
    logic                          fits;

    assign trial = {rem_reg, q_reg[31]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= kli_pkg::DIV_CNT_W'(kli_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy)
        begin
            // The remainder stays below the divisor, so 16 bits hold it.
            rem_reg <= fits ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = q_reg;

endmodule

/* sv/kli_dp.sv */
// Datapath of the keyframe interpolator: key tables, scan compare, divider,
// shared multiplier and output register. Depends on kli_pkg and kli_div.
module kli_dp #(
    parameter int MAX_KEYS       = 64,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kli_pkg::cfg_t                    cfg,
    input  kli_pkg::req_t                    req_data,
    input  kli_pkg::cmd_t                    cmd,
    output kli_pkg::sts_t                    sts,
    input  logic                             res_ready,
    output logic                             res_valid,
    output logic signed [kli_pkg::VAL_W-1:0] value0,
    output logic signed [kli_pkg::VAL_W-1:0] value1,
    output logic signed [kli_pkg::VAL_W-1:0] value2,
    output logic signed [kli_pkg::VAL_W-1:0] value3,
    output logic [1:0]                       status
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int WW = MAX_COMPONENTS * kli_pkg::VAL_W;
    localparam int LN = kli_pkg::LANES;

    // Key tables.
    logic [kli_pkg::TIME_W-1:0] tmem [MAX_KEYS];
    logic [WW-1:0]              vmem [MAX_KEYS];
    logic [kli_pkg::TIME_W-1:0] rd_time_reg;
    logic [WW-1:0]              rd_val_reg;

    logic [WW-1:0]   wr_word;
    logic [31:0]     comp_in [LN];
    logic [31:0]     rd_lane [LN];
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [IW-1:0]   taddr;
    logic [IW-1:0]   vaddr;

    // Query state.
    logic signed [kli_pkg::VIEW_W-1:0] view_in;
    logic signed [kli_pkg::VIEW_W-1:0] view_reg;
    logic signed [kli_pkg::VIEW_W-1:0] num_s;
    logic signed [16:0]                den_s;
    logic [IW-1:0]                     scan_idx_reg;
    logic [IW-1:0]                     a_idx_reg;
    logic [IW-1:0]                     b_idx_reg;
    logic [kli_pkg::TIME_W-1:0]        prev_time_reg;
    logic [kli_pkg::TIME_W-1:0]        next_time_reg;
    kli_pkg::status_t                  status_reg;
    logic                              den_pos_reg;

    logic [CW-1:0]   n_keys;
    logic [CW-1:0]   n_keys_m1;
    logic [IW-1:0]   last_idx;
    logic [2:0]      nc;
    logic [2:0]      nc_m1;
    logic            hit;

    // Divider and lerp.
    logic            div_start;
    logic            div_busy;
    logic [31:0]     div_num;
    logic [31:0]     div_quot;
    logic [kli_pkg::FRAC_W-1:0] frac;

    logic signed [31:0] a_reg [LN];
    logic signed [31:0] b_reg [LN];
    logic signed [31:0] res_reg [LN];
    logic signed [32:0] diff;
    logic signed [50:0] prod_next;
    logic signed [50:0] prod_reg;
    logic [kli_pkg::LANE_W-1:0] lane_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] out_val_reg [LN];
    logic [1:0]         out_status_reg;

    assign comp_in[0] = req_data.comp0;
    assign comp_in[1] = req_data.comp1;
    assign comp_in[2] = req_data.comp2;
    assign comp_in[3] = req_data.comp3;

    for (genvar l = 0; l < LN; l++)
    begin : g_lane
        if (l < MAX_COMPONENTS)
        begin : g_used
            assign wr_word[l*kli_pkg::VAL_W +: kli_pkg::VAL_W] = comp_in[l];
            assign rd_lane[l] = rd_val_reg[l*kli_pkg::VAL_W +: kli_pkg::VAL_W];
        end
        else
        begin : g_unused
            assign rd_lane[l] = '0;
        end
    end

    // Slots beyond the table are dropped.
    assign wr_en   = cmd.wr && (32'(req_data.entry_index) < MAX_KEYS);
    assign wr_addr = IW'(req_data.entry_index);

    assign taddr = cmd.start ? '0 : IW'(scan_idx_reg + 1'b1);
    assign vaddr = cmd.rd_b ? b_idx_reg : a_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tmem[wr_addr] <= req_data.entry_time;
            vmem[wr_addr] <= wr_word;
        end
        rd_time_reg <= tmem[taddr];
        rd_val_reg  <= vmem[vaddr];
    end

    assign n_keys    = (32'(cfg.keyframe_count) > MAX_KEYS) ? CW'(MAX_KEYS)
                                                            : CW'(cfg.keyframe_count);
    assign n_keys_m1 = n_keys - CW'(1);
    assign last_idx  = IW'(n_keys_m1);

    always_comb
    begin
        if (cfg.component_count == 3'd0)
            nc = 3'd1;
        else if (32'(cfg.component_count) > MAX_COMPONENTS)
            nc = 3'(MAX_COMPONENTS);
        else
            nc = cfg.component_count;
    end
    assign nc_m1 = nc - 3'd1;

    // Frame-based view times can go negative, so the compare is signed.
    assign view_in = (req_data.query_time != '0)
        ? $signed({2'b00, req_data.query_time})
        : $signed({2'b00, req_data.current_frame}) - $signed({2'b00, cfg.begin_frame, 16'd0});

    assign hit   = view_reg <= $signed({2'b00, rd_time_reg, 16'd0});
    assign num_s = view_reg - $signed({2'b00, prev_time_reg, 16'd0});
    assign den_s = $signed({1'b0, next_time_reg}) - $signed({1'b0, prev_time_reg});

    assign div_start = cmd.rd_b && (status_reg == kli_pkg::ST_INTERP);
    assign div_num   = (num_s < 0) ? 32'd0 : num_s[31:0];

    kli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_s[15:0]),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Held keys load the same entry into both ends, so any fraction gives it.
    always_comb
    begin
        if (status_reg != kli_pkg::ST_INTERP)
            frac = '0;
        else if (!den_pos_reg)
            frac = kli_pkg::FRAC_ONE;
        else if (div_quot > 32'(kli_pkg::FRAC_ONE))
            frac = kli_pkg::FRAC_ONE;
        else
            frac = div_quot[kli_pkg::FRAC_W-1:0];
    end

    assign diff      = {b_reg[lane_reg][31], b_reg[lane_reg]}
                     - {a_reg[lane_reg][31], a_reg[lane_reg]};
    assign prod_next = diff * $signed({1'b0, frac});

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            view_reg     <= view_in;
            scan_idx_reg <= '0;
            status_reg   <= (n_keys == '0) ? kli_pkg::ST_EMPTY : kli_pkg::ST_INTERP;
            for (int l = 0; l < LN; l++)
            begin
                res_reg[l] <= '0;
            end
        end
        if (cmd.scan)
        begin
            scan_idx_reg <= IW'(scan_idx_reg + 1'b1);
            if (!hit)
            begin
                prev_time_reg <= rd_time_reg;
            end
            if (hit && (scan_idx_reg == '0))
            begin
                a_idx_reg  <= '0;
                b_idx_reg  <= '0;
                status_reg <= kli_pkg::ST_HELD_FIRST;
            end
            else if (hit)
            begin
                a_idx_reg     <= IW'(scan_idx_reg - 1'b1);
                b_idx_reg     <= scan_idx_reg;
                next_time_reg <= rd_time_reg;
                status_reg    <= kli_pkg::ST_INTERP;
            end
            else if (scan_idx_reg == last_idx)
            begin
                a_idx_reg  <= scan_idx_reg;
                b_idx_reg  <= scan_idx_reg;
                status_reg <= kli_pkg::ST_HELD_LAST;
            end
        end
        if (cmd.rd_b)
        begin
            den_pos_reg <= den_s > 0;
            for (int l = 0; l < LN; l++)
            begin
                a_reg[l] <= rd_lane[l];
            end
        end
        if (cmd.cap_b)
        begin
            lane_reg <= '0;
            for (int l = 0; l < LN; l++)
            begin
                b_reg[l] <= rd_lane[l];
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.add)
        begin
            // The arithmetic shift by 16 floors the scaled difference.
            res_reg[lane_reg] <= a_reg[lane_reg] + prod_reg[47:16];
            lane_reg          <= lane_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            for (int l = 0; l < LN; l++)
            begin
                out_val_reg[l] <= res_reg[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.empty     = n_keys == '0;
    assign sts.hit       = hit;
    assign sts.last      = scan_idx_reg == last_idx;
    assign sts.interp    = status_reg == kli_pkg::ST_INTERP;
    assign sts.div_busy  = div_busy;
    assign sts.comp_last = lane_reg == nc_m1[kli_pkg::LANE_W-1:0];
    assign sts.out_free  = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign value0    = out_val_reg[0];
    assign value1    = out_val_reg[1];
    assign value2    = out_val_reg[2];
    assign value3    = out_val_reg[3];
    assign status    = out_status_reg;

endmodule

/* sv/kli_ctrl.sv */
// Control state machine of the keyframe interpolator: scan, fetch, divide,
// per-component lerp and result hand-off. Depends on kli_pkg.
module kli_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_type,
    output logic          req_ready,
    input  kli_pkg::sts_t sts,
    output kli_pkg::cmd_t cmd
);

    kli_pkg::state_t state_reg;
    kli_pkg::state_t state_next;
    logic            take;

    assign take = req_valid && (state_reg == kli_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kli_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kli_pkg::S_IDLE:
            begin
                if (take && (req_type == kli_pkg::REQ_QUERY))
                    state_next = sts.empty ? kli_pkg::S_OUT : kli_pkg::S_SCAN;
            end
            kli_pkg::S_SCAN:
            begin
                if (sts.hit || sts.last)
                    state_next = kli_pkg::S_RD_A;
            end
            kli_pkg::S_RD_A:  state_next = kli_pkg::S_RD_B;
            kli_pkg::S_RD_B:  state_next = kli_pkg::S_CAP_B;
            kli_pkg::S_CAP_B: state_next = sts.interp ? kli_pkg::S_DIV : kli_pkg::S_MUL;
            kli_pkg::S_DIV:
            begin
                if (!sts.div_busy)
                    state_next = kli_pkg::S_MUL;
            end
            kli_pkg::S_MUL:   state_next = kli_pkg::S_ADD;
            kli_pkg::S_ADD:   state_next = sts.comp_last ? kli_pkg::S_OUT : kli_pkg::S_MUL;
            kli_pkg::S_OUT:
            begin
                if (sts.out_free)
                    state_next = kli_pkg::S_IDLE;
            end
            default:          state_next = kli_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            kli_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.wr    = take && (req_type == kli_pkg::REQ_WRITE);
                cmd.start = take && (req_type == kli_pkg::REQ_QUERY);
            end
            kli_pkg::S_SCAN:  cmd.scan     = 1'b1;
            kli_pkg::S_RD_A:  ;
            kli_pkg::S_RD_B:  cmd.rd_b     = 1'b1;
            kli_pkg::S_CAP_B: cmd.cap_b    = 1'b1;
            kli_pkg::S_DIV:   ;
            kli_pkg::S_MUL:   cmd.mul      = 1'b1;
            kli_pkg::S_ADD:   cmd.add      = 1'b1;
            kli_pkg::S_OUT:   cmd.out_load = sts.out_free;
            default:          ;
        endcase
    end

endmodule

/* sv/keyframe_linear_interpolator.sv */
// Top level of the keyframe linear interpolator: registers, controller, datapath.
// Depends on kli_pkg, kli_if, kli_regs, kli_ctrl, kli_dp and assert_macros.svh.
//
//   Channel   Direction   Transfer when              Carries
//   req       in          req.valid && req.ready     keyframe write or query
//   res       out         res.valid && res.ready     four values and status
//   apb       in          psel&&penable&&pwrite      config register write
//
// A write is taken in the idle state and leaves the input ready. A query with an empty
// table goes straight to the output state; otherwise it scans the keys, one a cycle
// through the time table port, reads both end keys, runs the bit-serial divider when
// it interpolates, and multiplies and adds once per component before the output.
// The result register frees the input side; a query finishing while the previous
// result is still untaken waits for it. Reset clears control and config state only.
`include "assert_macros.svh"

module keyframe_linear_interpolator #(
    parameter int MAX_KEYS       = 64,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    kli_req_if.sink                     req,
    kli_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kli_pkg::ADDR_W-1:0]  paddr,
    input  logic [kli_pkg::DATA_W-1:0]  pwdata,
    output logic [kli_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    kli_pkg::cfg_t cfg;
    kli_pkg::req_t req_data;
    kli_pkg::cmd_t cmd;
    kli_pkg::sts_t sts;

    assign req_data.req_type      = req.req_type;
    assign req_data.entry_index   = req.entry_index;
    assign req_data.entry_time    = req.entry_time;
    assign req_data.comp0         = req.comp0;
    assign req_data.comp1         = req.comp1;
    assign req_data.comp2         = req.comp2;
    assign req_data.comp3         = req.comp3;
    assign req_data.current_frame = req.current_frame;
    assign req_data.query_time    = req.query_time;

    kli_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kli_dp #(
        .MAX_KEYS       (MAX_KEYS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .value0    (res.value0),
        .value1    (res.value1),
        .value2    (res.value2),
        .value3    (res.value3),
        .status    (res.status)
    );

    `KLI_ASSERT_NEXT(a_query_holds_off, clk, rst_n, req.valid && req.ready && (req.req_type == kli_pkg::REQ_QUERY), !req.ready, "input still ready after a query transfer")
    `KLI_ASSERT_NEXT(a_write_no_stall, clk, rst_n, req.valid && req.ready && (req.req_type == kli_pkg::REQ_WRITE), req.ready, "input stalled after a write transfer")
    `KLI_ASSERT_IMPL(a_out_load_free, clk, rst_n, cmd.out_load, !res.valid || res.ready, "result loaded over an untaken result")

endmodule

/* dv/tb_keyframe_linear_interpolator.sv */
// Self-checking testbench for keyframe_linear_interpolator: keyframe tables are
// written through the request channel and every query result is predicted and checked.
// Depends on kli_pkg, kli_if and the RTL of the block.

typedef struct packed {
    logic [3:0][31:0] vals;
    kli_pkg::status_t status;
} interp_result_t;

class interp_scoreboard;
    logic [15:0]        key_time [64];
    logic signed [31:0] key_val  [64][4];
    logic [15:0]        begin_frame;
    logic [2:0]         comp_count;
    logic [6:0]         key_count;
    interp_result_t     expected_q [$];
    int                 errors;

    function new();
        begin_frame = '0;
        comp_count  = 3'd1;
        key_count   = '0;
        errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            kli_pkg::REG_BEGIN_FRAME:     begin_frame = value[15:0];
            kli_pkg::REG_COMPONENT_COUNT: comp_count  = value[2:0];
            kli_pkg::REG_KEYFRAME_COUNT:  key_count   = value[6:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function interp_result_t interpolate(kli_pkg::req_t r);
        interp_result_t out_r;
        longint         view;
        longint         prev_t;
        longint         next_t;
        longint         den;
        longint         num;
        longint         frac;
        longint         a;
        longint         b;
        longint         lerp;
        int             n;
        int             nc;
        int             hit;
        int             k;
        bit             found;
        out_r = '0;
        n = (key_count > 7'd64) ? 64 : int'(key_count);
        nc = (comp_count == 3'd0) ? 1 : ((comp_count > 3'd4) ? 4 : int'(comp_count));
        if (n == 0)
        begin
            out_r.status = kli_pkg::ST_EMPTY;
            return out_r;
        end
        // A nonzero explicit time wins; the frame-based time may go negative.
        if (r.query_time != 32'd0)
            view = longint'(r.query_time);
        else
            view = longint'(r.current_frame) - longint'(begin_frame) * 65536;
        found = 1'b0;
        hit = 0;
        for (int i = 0; i < n && !found; i++)
        begin
            if (view <= longint'(key_time[i]) * 65536)
            begin
                hit = i;
                found = 1'b1;
            end
        end
        if (!found || hit == 0)
        begin
            k = found ? 0 : n - 1;
            for (int c = 0; c < nc; c++)
                out_r.vals[c] = key_val[k][c];
            out_r.status = found ? kli_pkg::ST_HELD_FIRST : kli_pkg::ST_HELD_LAST;
            return out_r;
        end
        prev_t = longint'(key_time[hit - 1]);
        next_t = longint'(key_time[hit]);
        den = next_t - prev_t;
        frac = 65536;
        if (den > 0)
        begin
            num = view - prev_t * 65536;
            if (num < 0)
                num = 0;
            frac = num / den;
            if (frac > 65536)
                frac = 65536;
        end
        for (int c = 0; c < nc; c++)
        begin
            a = longint'(key_val[hit - 1][c]);
            b = longint'(key_val[hit][c]);
            // Arithmetic shift of a signed product rounds toward minus infinity.
            lerp = a + (((b - a) * frac) >>> 16);
            out_r.vals[c] = 32'(lerp);
        end
        out_r.status = kli_pkg::ST_INTERP;
        return out_r;
    endfunction

    function void note_request(kli_pkg::req_t r);
        if (r.req_type == kli_pkg::REQ_WRITE)
        begin
            key_time[r.entry_index]   = r.entry_time;
            key_val[r.entry_index][0] = r.comp0;
            key_val[r.entry_index][1] = r.comp1;
            key_val[r.entry_index][2] = r.comp2;
            key_val[r.entry_index][3] = r.comp3;
        end
        else
            expected_q.insert(expected_q.size(), interpolate(r));
    endfunction

    function void check_result(interp_result_t got);
        interp_result_t exp_r;
        if (expected_q.size() == 0)
        begin
            $error("result transfer with no query outstanding");
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        for (int c = 0; c < 4; c++)
        begin
            if (got.vals[c] !== exp_r.vals[c])
            begin
                $error("value%0d: expected %h, actual %h", c, exp_r.vals[c], got.vals[c]);
                errors++;
            end
        end
        if (got.status !== exp_r.status)
        begin
            $error("status: expected %0d, actual %0d", exp_r.status, got.status);
            errors++;
        end
    endfunction
endclass

module tb_keyframe_linear_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS        = 1200;
    localparam int CALM_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 500;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kli_req_if req_ch ();
    kli_res_if res_ch ();

    interp_scoreboard sb = new();

    logic [15:0] planned_times [64];
    int          items_sent     = 0;
    int          src_idle_pct   = 0;
    int          sink_idle_pct  = 0;
    int          stall_left     = 0;
    int          cycle_count    = 0;
    bit          calm           = 1'b0;
    bit          want_long_hold = 1'b0;

    keyframe_linear_interpolator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keyframe_linear_interpolator regression: fail");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (want_long_hold)
        begin
            want_long_hold = 1'b0;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0 && !calm && $urandom_range(0, 99) < sink_idle_pct)
            stall_left = $urandom_range(1, 13);
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_monitor
        interp_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.vals[0] = res_ch.value0;
            got.vals[1] = res_ch.value1;
            got.vals[2] = res_ch.value2;
            got.vals[3] = res_ch.value3;
            got.status  = kli_pkg::status_t'(res_ch.status);
            sb.check_result(got);
        end
    end

    function automatic int table_size();
        return (sb.key_count > 7'd64) ? 64 : int'(sb.key_count);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(-$urandom_range(0, 32'h3_0000));
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] bf, input logic [2:0] cc, input logic [6:0] kc);
        write_reg(kli_pkg::REG_BEGIN_FRAME, 32'(bf));
        write_reg(kli_pkg::REG_COMPONENT_COUNT, 32'(cc));
        write_reg(kli_pkg::REG_KEYFRAME_COUNT, 32'(kc));
    endtask

    task automatic push_item(input kli_pkg::req_t r);
        int gap;
        if (!calm && $urandom_range(0, 99) < src_idle_pct)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.req_type;
        req_ch.entry_index   <= r.entry_index;
        req_ch.entry_time    <= r.entry_time;
        req_ch.comp0         <= r.comp0;
        req_ch.comp1         <= r.comp1;
        req_ch.comp2         <= r.comp2;
        req_ch.comp3         <= r.comp3;
        req_ch.current_frame <= r.current_frame;
        req_ch.query_time    <= r.query_time;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        sb.note_request(r);
        items_sent++;
        if (r.req_type == kli_pkg::REQ_WRITE)
            planned_times[r.entry_index] = r.entry_time;
    endtask

    task automatic send_write(input int slot, input logic [15:0] t, input logic [31:0] v0,
                              input logic [31:0] v1, input logic [31:0] v2,
                              input logic [31:0] v3);
        kli_pkg::req_t r;
        r.req_type      = kli_pkg::REQ_WRITE;
        r.entry_index   = 6'(slot);
        r.entry_time    = t;
        r.comp0         = v0;
        r.comp1         = v1;
        r.comp2         = v2;
        r.comp3         = v3;
        r.current_frame = $urandom;
        r.query_time    = $urandom;
        push_item(r);
    endtask

    task automatic query(input logic [31:0] qt, input logic [31:0] cf);
        kli_pkg::req_t r;
        r.req_type      = kli_pkg::REQ_QUERY;
        r.entry_index   = 6'($urandom);
        r.entry_time    = 16'($urandom);
        r.comp0         = $urandom;
        r.comp1         = $urandom;
        r.comp2         = $urandom;
        r.comp3         = $urandom;
        r.current_frame = cf;
        r.query_time    = qt;
        push_item(r);
    endtask

    // Writes slots 0..n-1 with ascending times, with some equal neighbors.
    task automatic fill_table(input int n);
        int mode;
        int t;
        mode = $urandom_range(0, 3);
        case (mode)
            0: t = $urandom_range(0, 20);
            3: t = $urandom_range(60000, 65535);
            default: t = $urandom_range(0, 5000);
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) != 0)
                t += (mode == 1) ? $urandom_range(1, 3) : $urandom_range(1, 2000);
            if (t > 65535)
                t = 65535;
            send_write(i, 16'(t), rand_value(), rand_value(), rand_value(), rand_value());
        end
    endtask

    // Query whose view time lands on or near a key of the current table.
    task automatic query_near();
        int     n;
        int     j;
        int     pick;
        longint view;
        n = table_size();
        if (n == 0)
        begin
            query($urandom, $urandom);
            return;
        end
        j = $urandom_range(0, n - 1);
        pick = $urandom_range(0, 9);
        view = longint'(planned_times[j]) * 65536;
        if (pick == 1)
            view += 1;
        else if (pick == 2)
            view -= 1;
        else if (pick >= 3)
            view += longint'($urandom_range(0, 262144)) - 131072;
        if (view > 0 && view <= 64'hFFFF_FFFF && $urandom_range(0, 1) == 1)
            query(32'(view), $urandom);
        else
            query(32'h0, 32'(view + longint'(sb.begin_frame) * 65536));
    endtask

    // Rewrites a key with a time that keeps the table in ascending order.
    task automatic rewrite_in_order();
        int n;
        int j;
        int lo;
        int hi;
        n = table_size();
        if (n == 0)
        begin
            send_write($urandom_range(0, 63), 16'($urandom), rand_value(), rand_value(),
                       rand_value(), rand_value());
            return;
        end
        j = $urandom_range(0, n - 1);
        lo = (j > 0) ? int'(planned_times[j - 1]) : 0;
        hi = (j < n - 1) ? int'(planned_times[j + 1]) : 65535;
        send_write(j, 16'($urandom_range(lo, hi)), rand_value(), rand_value(),
                   rand_value(), rand_value());
    endtask

    task automatic noise_item();
        if ($urandom_range(0, 1) == 0)
            send_write($urandom_range(0, 63), 16'($urandom), $urandom, $urandom,
                       $urandom, $urandom);
        else if ($urandom_range(0, 9) == 0)
            query(32'h0, $urandom);
        else
            query($urandom, $urandom);
    endtask

    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_idle_pct(input bit sink_side);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return sink_side ? 3 : 8;
            2: return sink_side ? 10 : 25;
            default: return sink_side ? 25 : 50;
        endcase
    endfunction

    initial
    begin
        int          phase;
        int          nq;
        int          sel;
        logic [15:0] bf;
        logic [2:0]  cc;
        logic [6:0]  kc;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        res_ch.ready         = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = kli_pkg::REQ_WRITE;
        req_ch.entry_index   = '0;
        req_ch.entry_time    = '0;
        req_ch.comp0         = '0;
        req_ch.comp1         = '0;
        req_ch.comp2         = '0;
        req_ch.comp3         = '0;
        req_ch.current_frame = '0;
        req_ch.query_time    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings leave the table empty.
        query(32'h0001_0000, $urandom);
        settle();

        configure(16'd2, 3'd4, 7'd4);
        send_write(0, 16'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_write(1, 16'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h1);
        send_write(2, 16'd5, rand_value(), rand_value(), rand_value(), rand_value());
        send_write(3, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, rand_value());
        query(32'h0001_0000, $urandom);
        query(32'h0002_0000, $urandom);
        query(32'h0003_8000, $urandom);
        query(32'h0005_0000, $urandom);
        query(32'h0005_0001, $urandom);
        query(32'hFFFF_0000, $urandom);
        query(32'hFFFF_FFFF, $urandom);
        query(32'h0, 32'h0);
        query(32'h0, 32'h0004_0000);
        query(32'h0, 32'h0006_8000);
        query(32'h0, 32'hFFFF_FFFF);
        settle();

        phase = 0;
        while (items_sent < ITEMS)
        begin
            phase++;
            calm = (items_sent >= ITEMS - CALM_ITEMS);
            src_idle_pct  = calm ? 0 : pick_idle_pct(1'b0);
            sink_idle_pct = calm ? 0 : pick_idle_pct(1'b1);
            bf = 16'($urandom);
            case (phase)
                1:
                begin
                    bf = 16'hFFFF;
                    cc = 3'd4;
                    kc = 7'd64;
                end
                2:
                begin
                    bf = 16'h0;
                    cc = 3'd0;
                    kc = 7'd127;
                end
                3:
                begin
                    cc = 3'd7;
                    kc = 7'd6;
                    src_idle_pct = 0;
                end
                4:
                begin
                    cc = 3'd1;
                    kc = 7'd0;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: bf = 16'h0;
                        1: bf = 16'hFFFF;
                        2: bf = 16'($urandom_range(0, 300));
                        default: ;
                    endcase
                    cc = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 4))
                                                     : 3'($urandom_range(0, 7));
                    case ($urandom_range(0, 11))
                        0: kc = 7'd0;
                        1: kc = 7'd1;
                        2: kc = 7'd64;
                        3: kc = 7'($urandom_range(65, 127));
                        4: kc = 7'd2;
                        default: kc = 7'($urandom_range(2, 12));
                    endcase
                end
            endcase
            configure(bf, cc, kc);
            fill_table(table_size());
            nq = (phase == 3) ? 40 : $urandom_range(15, 50);
            // The result side stops taking transfers so queries back up at the input.
            if (phase == 3)
                want_long_hold = 1'b1;
            repeat (nq)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 75)
                    query_near();
                else if (sel < 85)
                    rewrite_in_order();
                else
                    noise_item();
            end
            settle();
        end

        if (sb.errors == 0)
            $display("keyframe_linear_interpolator regression: pass");
        else
            $display("keyframe_linear_interpolator regression: fail");
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/kli_pkg.sv
sv/kli_if.sv
sv/kli_regs.sv
sv/kli_div.sv
sv/kli_dp.sv
sv/kli_ctrl.sv
sv/keyframe_linear_interpolator.sv
dv/tb_keyframe_linear_interpolator.sv
